// ===== src/shs_pkg.sv =====
// Shared types, constants and bit functions for the SHA-256 stream hasher.
// No dependencies; imported by shs_round, shs_sched and the top level.
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] wvars_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } shs_state_e;

  typedef struct packed {
    logic load_byte;
    logic shift_word;
  } shs_sched_ctrl_t;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] IDX_LAST   = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam wvars_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// ===== src/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher top level: byte intake, padding sequencer, round loop
// and digest output. Depends on shs_pkg, shs_sched and shs_round.
//
//  channel  | dir | tdata            | tuser         | tlast
//  s_axis   | in  | byte_value[7:0]  | byte_present  | end_of_message
//  m_axis   | out | digest_word[31:0]| word_index    | last_word
//
// A byte request that does not complete a block is accepted in the idle state.
// A full block holds off requests while it runs 64 rounds on the shared
// round unit and then one fold into the chaining words.
// End of message: one pad byte per cycle up to the block end, one or two
// compressions, then eight digest words, one per output handshake.
// Reset loads the initial chaining words; no request is taken while busy.
module sha256_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_value
  input  logic        s_axis_tuser_i,   // byte_present
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // digest_word
  output logic [2:0]  m_axis_tuser_o,   // word_index
  output logic        m_axis_tlast_o
);
  import shs_pkg::*;

  shs_state_e      state_q, state_d;
  logic [5:0]      fill_q, fill_d;
  logic [60:0]     count_q, count_d;
  logic [63:0]     len_q, len_d;
  logic            sent80_q, sent80_d;
  logic            final_q, final_d;
  logic            padm_q, padm_d;
  logic [5:0]      rnd_q, rnd_d;
  logic [2:0]      idx_q, idx_d;
  wvars_t          h_q, h_d;
  wvars_t          v_q, v_d;
  wvars_t          v_next;
  word_t           w_t;
  shs_sched_ctrl_t sched_ctrl;
  logic [7:0]      byte_sel;
  logic [7:0]      pad_byte;

  shs_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .byte_i (byte_sel),
    .w_o    (w_t)
  );

  shs_round u_round (
    .v_i (v_q),
    .k_i (K_TAB[rnd_q]),
    .w_i (w_t),
    .v_o (v_next)
  );

  always_comb begin
    if (!sent80_q) begin
      pad_byte = PAD_MARK;
    end else if (final_q && (fill_q >= LEN_POS)) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d         = state_q;
    fill_d          = fill_q;
    count_d         = count_q;
    len_d           = len_q;
    sent80_d        = sent80_q;
    final_d         = final_q;
    padm_d          = padm_q;
    rnd_d           = rnd_q;
    idx_d           = idx_q;
    h_d             = h_q;
    v_d             = v_q;
    sched_ctrl      = '0;
    byte_sel        = s_axis_tdata_i;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i) begin
            sched_ctrl.load_byte = 1'b1;
            fill_d  = fill_q + 6'd1;
            count_d = count_q + 61'd1;
          end
          if (s_axis_tlast_i) begin
            padm_d   = 1'b1;
            sent80_d = 1'b0;
            final_d  = 1'b0;
            len_d    = {count_d, 3'b000};
          end
          if (s_axis_tuser_i && (fill_q == FILL_LAST)) begin
            v_d     = h_q;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_sel             = pad_byte;
        sched_ctrl.load_byte = 1'b1;
        fill_d               = fill_q + 6'd1;
        if (!sent80_q) begin
          sent80_d = 1'b1;
          final_d  = (fill_q < LEN_POS);
        end else if (final_q && (fill_q >= LEN_POS)) begin
          len_d = {len_q[55:0], 8'h00};
        end
        if (fill_q == FILL_LAST) begin
          v_d     = h_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        sched_ctrl.shift_word = 1'b1;
        v_d   = v_next;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (padm_q) begin
          if (final_q) begin
            idx_d   = '0;
            state_d = ST_OUT;
          end else begin
            final_d = sent80_q;
            state_d = ST_PAD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == IDX_LAST) begin
            h_d     = H_INIT;
            count_d = '0;
            padm_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      count_q  <= '0;
      sent80_q <= 1'b0;
      final_q  <= 1'b0;
      padm_q   <= 1'b0;
      rnd_q    <= '0;
      idx_q    <= '0;
      h_q      <= H_INIT;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      sent80_q <= sent80_d;
      final_q  <= final_d;
      padm_q   <= padm_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      h_q      <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    v_q   <= v_d;
  end

  assign m_axis_tdata_o = h_q[idx_q];
  assign m_axis_tuser_o = idx_q;
  assign m_axis_tlast_o = (idx_q == IDX_LAST);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output active together");

  a_round_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && (rnd_q != ROUND_LAST)
      |=> (state_q == ST_ROUND) && (rnd_q == $past(rnd_q) + 6'd1))
    else $error("round counter broke sequence");

  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (fill_q == '0) && final_q && sent80_q)
    else $error("digest output with block not closed");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o
      |=> s_axis_tready_o && (h_q == H_INIT) && (count_q == '0))
    else $error("chaining state not restored after digest");

endmodule

// ===== src/shs_round.sv =====
// One SHA-256 compression round on the working variables a..h.
// Depends on shs_pkg for word types and the big sigma functions.
module shs_round (
  input  shs_pkg::wvars_t v_i,
  input  shs_pkg::word_t  k_i,
  input  shs_pkg::word_t  w_i,
  output shs_pkg::wvars_t v_o
);
  import shs_pkg::*;

  word_t ch, maj, t1, t2;

  always_comb begin
    ch    = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj   = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1    = v_i[7] + bsig1(v_i[4]) + ch + k_i + w_i;
    t2    = bsig0(v_i[0]) + maj;
    v_o[0] = t1 + t2;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];
  end

endmodule

// ===== src/shs_sched.sv =====
// Block gather and message schedule: a 16-word shift line that takes bytes
// while filling and expands W during rounds. Depends on shs_pkg.
module shs_sched (
  input  logic                     clk_i,
  input  shs_pkg::shs_sched_ctrl_t ctrl_i,
  input  logic [7:0]               byte_i,
  output shs_pkg::word_t           w_o
);
  import shs_pkg::*;

  word_t sched_q [16];
  word_t sched_d [16];
  word_t w_new;

  always_comb begin
    w_new = sig1(sched_q[14]) + sched_q[9] + sig0(sched_q[1]) + sched_q[0];
    for (int i = 0; i < 16; i++) begin
      sched_d[i] = sched_q[i];
    end
    if (ctrl_i.load_byte) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = {sched_q[i][23:0], sched_q[i+1][31:24]};
      end
      sched_d[15] = {sched_q[15][23:0], byte_i};
    end else if (ctrl_i.shift_word) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[15] = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      sched_q[i] <= sched_d[i];
    end
  end

  assign w_o = sched_q[0];

endmodule
